FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// Types, constants and the entry address helper for the four-level page table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

	localparam int ADDR_W    = 64;
	localparam int IDX_W     = 9;
	localparam int PAGE_W    = 12;
	localparam int PEND_W    = 39;
	localparam int L0_SHIFT  = 39;
	localparam int L1_SHIFT  = 30;
	localparam int L2_SHIFT  = 21;
	localparam int L3_SHIFT  = 12;
	localparam int VALID_BIT = 0;

	// input beat opcodes
	localparam logic MODE_TRANSLATE = 1'b0;
	localparam logic MODE_RESPONSE  = 1'b1;

	// result beat kinds
	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] vaddr;
		logic [ADDR_W-1:0] read_data;
	} flptw_in_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] read_addr;
		logic [ADDR_W-1:0] phys_addr;
		logic              found;
	} flptw_out_t;

	// table base with page bits cleared plus index times eight, wraps mod 2^64
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] table_ptr,
	                                                 input logic [IDX_W-1:0]  idx);
		logic [ADDR_W-1:0] page;
		logic [ADDR_W-1:0] offs;
		page = {table_ptr[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
		offs = {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
		return page + offs;
	endfunction

endpackage

FILE: rtl/flptw_in_reg.sv
// ----------------------------------------------------------------------------
// flptw_in_reg
// Input register: holds one beat until the walk core consumes it.
// ----------------------------------------------------------------------------
module flptw_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  flptw_pkg::flptw_in_t in_data,
	input  logic                advance,
	output logic                valid_s1,
	output flptw_pkg::flptw_in_t data_s1
);
	import flptw_pkg::*;

	// free when empty or when the held beat moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

FILE: rtl/flptw_walk_core.sv
// ----------------------------------------------------------------------------
// flptw_walk_core
// Walk state and the single-pass step logic for requests and responses.
// ----------------------------------------------------------------------------
module flptw_walk_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [flptw_pkg::ADDR_W-1:0] table_base,
	input  logic                        step_en,
	input  flptw_pkg::flptw_in_t        item,
	output logic                        res_valid,
	output flptw_pkg::flptw_out_t       res
);
	import flptw_pkg::*;

	typedef enum logic [1:0] {
		LVL_0 = 2'd0,
		LVL_1 = 2'd1,
		LVL_2 = 2'd2,
		LVL_3 = 2'd3
	} level_t;

	logic              busy_q;
	level_t            level_q;
	logic [PEND_W-1:0] pend_q;

	logic              busy_d;
	level_t            level_d;
	logic [PEND_W-1:0] pend_d;
	logic [IDX_W-1:0]  next_idx;

	// index for the next level's entry
	always_comb begin
		case (level_q)
			LVL_0:   next_idx = pend_q[L1_SHIFT +: IDX_W];
			LVL_1:   next_idx = pend_q[L2_SHIFT +: IDX_W];
			default: next_idx = pend_q[L3_SHIFT +: IDX_W];
		endcase
	end

	// step logic
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		busy_d    = busy_q;
		level_d   = level_q;
		pend_d    = pend_q;
		case (item.mode)
			MODE_TRANSLATE: begin
				// a request during a walk is dropped
				if (!busy_q) begin
					res_valid = 1'b1;
					if (table_base == '0) begin
						res.kind = KIND_RESULT;
					end else begin
						res.kind      = KIND_READ;
						res.read_addr = entry_addr(table_base,
						                           item.vaddr[L0_SHIFT +: IDX_W]);
						busy_d        = 1'b1;
						level_d       = LVL_0;
						pend_d        = item.vaddr[PEND_W-1:0];
					end
				end
			end
			MODE_RESPONSE: begin
				// a response with no walk running is dropped
				if (busy_q) begin
					res_valid = 1'b1;
					if (level_q == LVL_3) begin
						res.kind      = KIND_RESULT;
						res.phys_addr = {item.read_data[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}}
						              + {{(ADDR_W-PAGE_W){1'b0}}, pend_q[PAGE_W-1:0]};
						res.found     = 1'b1;
						busy_d        = 1'b0;
						level_d       = LVL_0;
					end else if (!item.read_data[VALID_BIT]) begin
						res.kind = KIND_RESULT;
						busy_d   = 1'b0;
						level_d  = LVL_0;
					end else begin
						res.kind      = KIND_READ;
						res.read_addr = entry_addr(item.read_data, next_idx);
						level_d       = level_t'(level_q + 2'd1);
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			level_q <= LVL_0;
			pend_q  <= '0;
		end else if (step_en) begin
			busy_q  <= busy_d;
			level_q <= level_d;
			pend_q  <= pend_d;
		end
	end

endmodule

FILE: rtl/flptw_out_reg.sv
// ----------------------------------------------------------------------------
// flptw_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module flptw_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  flptw_pkg::flptw_out_t load_data,
	output logic                  slot_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output flptw_pkg::flptw_out_t out_data
);
	import flptw_pkg::*;

	// can take a new beat when empty or when the held one leaves now
	assign slot_free = !out_valid || out_ready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			out_data <= load_data;
		end
	end

endmodule

FILE: rtl/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level, 4 KB granule page table walker with an external memory loop.
// ----------------------------------------------------------------------------
// Throughput is one input beat per cycle while the result side keeps up. A
// beat accepted into the input register passes one combinational step, is
// loaded into the result register when the result slot is free and is then
// offered from there as its result beat, if it produces one. A stalled
// result holds the input register, which then holds the input side off.
// The walk state is updated in the same step that builds the result, so a
// memory response may follow its read request in any later cycle. The
// configuration channel is always ready and loads table_base at once; write
// it only while no walk is running. Translate beats during a walk and
// response beats with no walk running produce no result.
module four_level_page_table_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [flptw_pkg::ADDR_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  flptw_pkg::flptw_in_t         in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output flptw_pkg::flptw_out_t        out_data
);
	import flptw_pkg::*;

	logic              table_base_q;
	logic [ADDR_W-1:0] table_base_r_q;
	logic              valid_s1;
	flptw_in_t         data_s1;
	logic              slot_free;
	logic              advance;
	logic              res_valid;
	flptw_out_t        res;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_r_q <= '0;
			table_base_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			table_base_r_q <= cfg_data;
			table_base_q   <= (cfg_data != '0);
		end
	end

	// held beat moves when the result slot can take it
	assign advance = valid_s1 && slot_free;

	flptw_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	flptw_walk_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_base (table_base_q ? table_base_r_q : '0),
		.step_en    (advance),
		.item       (data_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	flptw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_data (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/flptw_checker.sv
// ----------------------------------------------------------------------------
// flptw_checker
// Port-level checks on the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flptw_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input flptw_pkg::flptw_out_t out_data
);
	import flptw_pkg::*;

	logic out_stall;
	logic in_fire;
	logic rd_beat;
	logic rd_dirty;
	logic res_beat;

	// handshake and beat classes
	assign out_stall = out_valid && !out_ready;
	assign in_fire   = in_valid && in_ready;
	assign rd_beat   = out_valid && (out_data.kind == KIND_READ);
	assign res_beat  = out_valid && (out_data.kind == KIND_RESULT);
	assign rd_dirty  = (out_data.phys_addr != '0) || out_data.found;

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled beat changed")

	// a read request never carries a translation
	`ASSERT_IMPL(a_read_clean, rd_beat, !rd_dirty, "read request carries result fields")

	// a final result never carries a read address
	`ASSERT_IMPL(a_result_clean, res_beat, out_data.read_addr == '0, "result has a read address")

	// a fresh result comes from an input beat accepted ahead of it, through the input and result registers
	`ASSERT_IMPL(a_out_origin, $rose(out_valid), $past(in_fire, 2), "result with no source beat")

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (.*);
